/* hdl/tbp_pkg.sv */
package tbp_pkg;

	// Field widths of the branch and result transactions
	localparam int TBP_ADDR_W = 32;
	localparam int TBP_CNT_W  = 32;
	localparam int TBP_CTR_W  = 2;

	// Default geometry; TABLE_ENTRIES must be a power of two
	localparam int TBP_TABLE_ENTRIES = 2048;
	localparam int TBP_HISTORY_BITS  = 11;

	// Counter codes
	localparam logic [TBP_CTR_W-1:0] CTR_MAX         = 2'd3;
	localparam logic [TBP_CTR_W-1:0] CTR_MIN         = 2'd0;
	localparam logic [TBP_CTR_W-1:0] CTR_RESET       = CTR_MAX;
	localparam logic [TBP_CTR_W-1:0] CHOOSE_GSHARE_S = 2'd0;
	localparam logic [TBP_CTR_W-1:0] CHOOSE_BIMOD_S  = 2'd3;

	// Bimodal counter and chooser share an index, so they share an entry
	typedef struct packed {
		logic [TBP_CTR_W-1:0] chooser;
		logic [TBP_CTR_W-1:0] bimodal;
	} bc_entry_t;

endpackage

/* hdl/tbp_branch_if.sv */
interface tbp_branch_if
	import tbp_pkg::*;
	();

	logic                  valid;
	logic                  ready;
	logic [TBP_ADDR_W-1:0] branch_address;
	logic                  was_taken;

	modport source (output valid, output branch_address, output was_taken, input ready);
	modport sink   (input valid, input branch_address, input was_taken, output ready);

endinterface

/* hdl/tbp_result_if.sv */
interface tbp_result_if
	import tbp_pkg::*;
	();

	logic                 valid;
	logic                 ready;
	logic                 predicted_taken;
	logic                 prediction_correct;
	logic                 used_bimodal;
	logic [TBP_CNT_W-1:0] correct_total;
	logic [TBP_CNT_W-1:0] branch_total;

	modport source (
		output valid, output predicted_taken, output prediction_correct,
		output used_bimodal, output correct_total, output branch_total,
		input ready
	);
	modport sink (
		input valid, input predicted_taken, input prediction_correct,
		input used_bimodal, input correct_total, input branch_total,
		output ready
	);

endinterface

/* hdl/tournament_branch_predictor.sv */
// Channel  | Dir | Modport | Payload
// ---------+-----+---------+---------------------------------------------------------
// branch   | in  | sink    | branch_address[31:0], was_taken
// result   | out | source  | predicted_taken, prediction_correct, used_bimodal,
//          |     |         | correct_total[31:0], branch_total[31:0]
//
// One branch transaction per cycle sustained while result.ready holds; each is registered
// at the table read, then at the update into the output register.
// Throughput is set by the single read and single write port of each table memory.
// After reset a clearing pass writes the reset values into every entry of
// both memories; branch.ready stays low until it completes.
// A stalled result holds in the output register; the update stage keeps accepting
// until the output register is full and not being taken.
module tournament_branch_predictor
	import tbp_pkg::*;
#(
	parameter int TABLE_ENTRIES = TBP_TABLE_ENTRIES,
	parameter int HISTORY_BITS  = TBP_HISTORY_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	tbp_branch_if.sink      branch,
	tbp_result_if.source    result
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	function automatic logic [TBP_CTR_W-1:0] sat_step(
		input logic [TBP_CTR_W-1:0] ctr,
		input logic                 taken
	);
		logic [TBP_CTR_W-1:0] nxt;
		nxt = ctr;
		if (taken) begin
			if (ctr != CTR_MAX) nxt = ctr + 1'b1;
		end else begin
			if (ctr != CTR_MIN) nxt = ctr - 1'b1;
		end
		return nxt;
	endfunction

	// ---------------------------------------------------------------------
	// Clearing pass after reset
	// ---------------------------------------------------------------------
	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == IDX_W'(TABLE_ENTRIES - 1)) clr_busy_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------------
	// Handshake and stage control
	// ---------------------------------------------------------------------
	logic s1_vld_q;
	logic out_vld_q;
	logic s1_adv;
	logic in_fire;

	// update stage moves on when the output register is free or being emptied
	assign s1_adv       = s1_vld_q && (!out_vld_q || result.ready);
	assign branch.ready = !clr_busy_q && (!s1_vld_q || s1_adv);
	assign in_fire      = branch.valid && branch.ready;

	// ---------------------------------------------------------------------
	// Index generation; history moves at acceptance since the outcome is known
	// ---------------------------------------------------------------------
	logic [HISTORY_BITS-1:0] hist_q;
	logic [TBP_ADDR_W-1:0]   hist_ext;
	logic [IDX_W-1:0]        gi_in;
	logic [IDX_W-1:0]        bi_in;

	assign hist_ext = TBP_ADDR_W'(hist_q);
	assign gi_in    = IDX_W'(branch.branch_address ^ hist_ext);
	assign bi_in    = IDX_W'(branch.branch_address);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (in_fire) begin
			hist_q <= HISTORY_BITS'({hist_q, branch.was_taken});
		end
	end

	logic [IDX_W-1:0] gi_s1;
	logic [IDX_W-1:0] bi_s1;
	logic             taken_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (in_fire) begin
			s1_vld_q <= 1'b1;
		end else if (s1_adv) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			gi_s1    <= gi_in;
			bi_s1    <= bi_in;
			taken_s1 <= branch.was_taken;
		end
	end

	// ---------------------------------------------------------------------
	// Table memories: gshare counters, and bimodal counter with chooser
	// ---------------------------------------------------------------------
	logic [TBP_CTR_W-1:0] g_mem  [TABLE_ENTRIES];
	bc_entry_t            bc_mem [TABLE_ENTRIES];

	logic [TBP_CTR_W-1:0] g_rdata_s1;
	bc_entry_t            bc_rdata_s1;

	logic                 wr_en;
	logic [IDX_W-1:0]     g_waddr;
	logic [IDX_W-1:0]     bc_waddr;
	logic [TBP_CTR_W-1:0] g_wdata;
	bc_entry_t            bc_wdata;
	logic [TBP_CTR_W-1:0] g_new;
	bc_entry_t            bc_new;
	bc_entry_t            bc_clr;

	assign bc_clr   = '{chooser: CHOOSE_GSHARE_S, bimodal: CTR_RESET};
	assign wr_en    = clr_busy_q || s1_adv;
	assign g_waddr  = clr_busy_q ? clr_idx_q : gi_s1;
	assign bc_waddr = clr_busy_q ? clr_idx_q : bi_s1;
	assign g_wdata  = clr_busy_q ? CTR_RESET : g_new;
	assign bc_wdata = clr_busy_q ? bc_clr : bc_new;

	always_ff @(posedge clk) begin
		if (wr_en) g_mem[g_waddr] <= g_wdata;
		if (in_fire) g_rdata_s1 <= g_mem[gi_in];
	end

	always_ff @(posedge clk) begin
		if (wr_en) bc_mem[bc_waddr] <= bc_wdata;
		if (in_fire) bc_rdata_s1 <= bc_mem[bi_in];
	end

	// ---------------------------------------------------------------------
	// Forwarding: a read at the edge of a write returns the old entry, so the
	// most recent update is held and substituted on an index match.
	// ---------------------------------------------------------------------
	logic                 fwd_vld_q;
	logic [IDX_W-1:0]     g_fwd_idx_q;
	logic [IDX_W-1:0]     bc_fwd_idx_q;
	logic [TBP_CTR_W-1:0] g_fwd_data_q;
	bc_entry_t            bc_fwd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (s1_adv) begin
			fwd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			g_fwd_idx_q   <= gi_s1;
			bc_fwd_idx_q  <= bi_s1;
			g_fwd_data_q  <= g_new;
			bc_fwd_data_q <= bc_new;
		end
	end

	logic [TBP_CTR_W-1:0] g_cur;
	bc_entry_t            bc_cur;

	assign g_cur  = (fwd_vld_q && g_fwd_idx_q == gi_s1) ? g_fwd_data_q : g_rdata_s1;
	assign bc_cur = (fwd_vld_q && bc_fwd_idx_q == bi_s1) ? bc_fwd_data_q : bc_rdata_s1;

	// ---------------------------------------------------------------------
	// Prediction and update
	// ---------------------------------------------------------------------
	logic g_pred, b_pred, g_ok, b_ok, use_b, pred, ok;

	assign g_pred = g_cur[1];
	assign b_pred = bc_cur.bimodal[1];
	assign g_ok   = g_pred == taken_s1;
	assign b_ok   = b_pred == taken_s1;
	assign use_b  = bc_cur.chooser[1];
	assign pred   = use_b ? b_pred : g_pred;
	assign ok     = pred == taken_s1;

	logic [TBP_CTR_W-1:0] ch_new;

	always_comb begin
		ch_new = bc_cur.chooser;
		if (!use_b) begin
			// gshare chosen: strong gshare when only it was right, step away when only bimodal
			if (g_ok && !b_ok) ch_new = CHOOSE_GSHARE_S;
			else if (!g_ok && b_ok) ch_new = bc_cur.chooser + 1'b1;
		end else begin
			if (b_ok && !g_ok) ch_new = CHOOSE_BIMOD_S;
			else if (!b_ok && g_ok) ch_new = bc_cur.chooser - 1'b1;
		end
	end

	assign g_new  = sat_step(g_cur, taken_s1);
	assign bc_new = '{chooser: ch_new, bimodal: sat_step(bc_cur.bimodal, taken_s1)};

	// ---------------------------------------------------------------------
	// Running counts, saturating
	// ---------------------------------------------------------------------
	logic [TBP_CNT_W-1:0] correct_q, branch_q;
	logic [TBP_CNT_W-1:0] correct_nxt, branch_nxt;

	assign correct_nxt = (ok && correct_q != '1) ? correct_q + 1'b1 : correct_q;
	assign branch_nxt  = (branch_q != '1) ? branch_q + 1'b1 : branch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			correct_q <= '0;
			branch_q  <= '0;
		end else if (s1_adv) begin
			correct_q <= correct_nxt;
			branch_q  <= branch_nxt;
		end
	end

	// ---------------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------------
	logic                 pred_q, ok_q, use_b_q;
	logic [TBP_CNT_W-1:0] correct_out_q, branch_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pred_q        <= pred;
			ok_q          <= ok;
			use_b_q       <= use_b;
			correct_out_q <= correct_nxt;
			branch_out_q  <= branch_nxt;
		end
	end

	assign result.valid              = out_vld_q;
	assign result.predicted_taken    = pred_q;
	assign result.prediction_correct = ok_q;
	assign result.used_bimodal       = use_b_q;
	assign result.correct_total      = correct_out_q;
	assign result.branch_total       = branch_out_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !branch.ready)
		else $error("branch accepted during clearing pass");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_vld_q)
		else $error("update stage advanced without filling output register");

	a_correct_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (result.correct_total <= result.branch_total))
		else $error("correct count exceeds branch count");

	a_branch_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && branch_q != '1) |=> (branch_q == $past(branch_q) + 1'b1))
		else $error("branch count did not advance");

	a_history_shift: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (hist_q[0] == $past(branch.was_taken)))
		else $error("history did not take the outcome");

endmodule

/* bench/tournament_branch_predictor_tb.sv */
module tournament_branch_predictor_tb;
	import tbp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Geometry of the tables, as the default build of the block uses
	localparam int IDX_W = $clog2(TBP_TABLE_ENTRIES);
	localparam logic [TBP_ADDR_W-1:0] IDX_MASK = TBP_ADDR_W'(TBP_TABLE_ENTRIES - 1);

	// Slowest honest run: ~1450 transactions, each with the longest sender gap that
	// pick_gap gives and the longest receiver stall, plus the clearing pass and one long
	// hold-off. Taken several times over.
	localparam int LIMIT_CYCLES = 400000;
	localparam int N_RANDOM     = 1426;
	localparam int N_PROBE      = 24;
	localparam int N_HOT        = 16;
	localparam int LONG_HOLD    = 300;

	// What one resolved branch is expected to report
	typedef struct packed {
		logic                 predicted_taken;
		logic                 prediction_correct;
		logic                 used_bimodal;
		logic [TBP_CNT_W-1:0] correct_total;
		logic [TBP_CNT_W-1:0] branch_total;
	} branch_verdict_t;

	// Directed stimulus: address, outcome, and a hand-worked verdict where 'typed' is set
	typedef struct packed {
		logic [TBP_ADDR_W-1:0] addr;
		logic                  taken;
		logic                  typed;
		branch_verdict_t       want;
	} probe_row_t;

	// The first seven rows are worked by hand from the reset state:
	//  - fresh tables: gshare says taken, chooser favours gshare
	//  - top of the address space and aliases that differ only in high bits
	//  - bimodal counter on index 0 walked down to 0 while gshare keeps missing,
	//    so the chooser climbs one step at a time and then flips to bimodal
	// The rest lean on the predictor: chooser stepping back toward gshare,
	// alternating outcomes on one address, walking-ones style address patterns.
	probe_row_t probe_rows [N_PROBE] = '{
		'{32'h0000_0000, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 32'd1, 32'd1}},
		'{32'hFFFF_FFFF, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd1, 32'd2}},
		'{32'hFFFF_F800, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd1, 32'd3}},
		'{32'h0000_0800, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd1, 32'd4}},
		'{32'h0000_0000, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd1, 32'd5}},
		'{32'h0000_0000, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 32'd1, 32'd6}},
		'{32'h0000_0000, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 32'd2, 32'd7}},
		'{32'h0000_0000, 1'b1, 1'b0, '0},
		'{32'h0000_0000, 1'b1, 1'b0, '0},
		'{32'h0000_0000, 1'b1, 1'b0, '0},
		'{32'h0000_07FF, 1'b1, 1'b0, '0},
		'{32'h8000_07FF, 1'b0, 1'b0, '0},
		'{32'h7FFF_F800, 1'b1, 1'b0, '0},
		'{32'hAAAA_AAAA, 1'b1, 1'b0, '0},
		'{32'h5555_5555, 1'b0, 1'b0, '0},
		'{32'h0000_0123, 1'b1, 1'b0, '0},
		'{32'h0000_0123, 1'b0, 1'b0, '0},
		'{32'h0000_0123, 1'b1, 1'b0, '0},
		'{32'h0000_0123, 1'b0, 1'b0, '0},
		'{32'h0000_0123, 1'b1, 1'b0, '0},
		'{32'hFFFF_FFFF, 1'b1, 1'b0, '0},
		'{32'hFFFF_FFFF, 1'b1, 1'b0, '0},
		'{32'h8000_0000, 1'b0, 1'b0, '0},
		'{32'h0000_0001, 1'b1, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	tbp_branch_if branch_ch ();
	tbp_result_if result_ch ();

	tournament_branch_predictor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.branch (branch_ch),
		.result (result_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Shadow copy of the predictor state
	// ---------------------------------------------------------------------
	logic [TBP_CTR_W-1:0]        gshare_tab  [TBP_TABLE_ENTRIES];
	logic [TBP_CTR_W-1:0]        bimodal_tab [TBP_TABLE_ENTRIES];
	logic [TBP_CTR_W-1:0]        chooser_tab [TBP_TABLE_ENTRIES];
	logic [TBP_HISTORY_BITS-1:0] path_hist;
	logic [TBP_CNT_W-1:0]        hits_so_far;
	logic [TBP_CNT_W-1:0]        branches_so_far;

	// Verdicts awaiting their result transaction, oldest first
	branch_verdict_t pending_verdicts [$];

	int mismatches   = 0;
	int results_seen = 0;
	int bimodal_picks = 0;
	int right_calls  = 0;
	int branches_sent = 0;

	// Hot branches for the random part: loop-like and patterned outcomes
	logic [TBP_ADDR_W-1:0] hot_addr [N_HOT];
	logic [7:0]            hot_pat  [N_HOT];
	int                    hot_len  [N_HOT];
	int                    hot_pos  [N_HOT];

	// 2-bit saturating step toward the outcome
	function automatic logic [TBP_CTR_W-1:0] nudge_counter(logic [TBP_CTR_W-1:0] c, logic up);
		if (up)
			return (c == CTR_MAX) ? CTR_MAX : c + 1'b1;
		return (c == CTR_MIN) ? CTR_MIN : c - 1'b1;
	endfunction

	// Prediction for one resolved branch, then the tables, history and
	// counts are trained on its outcome
	function automatic branch_verdict_t train_on_branch(logic [TBP_ADDR_W-1:0] a, logic t);
		logic [IDX_W-1:0]     gi;
		logic [IDX_W-1:0]     bi;
		logic [TBP_CTR_W-1:0] g;
		logic [TBP_CTR_W-1:0] b;
		logic [TBP_CTR_W-1:0] ch;
		logic                 g_pred;
		logic                 b_pred;
		logic                 g_ok;
		logic                 b_ok;
		logic                 use_b;
		logic                 pred;
		branch_verdict_t      v;

		gi     = IDX_W'(a ^ TBP_ADDR_W'(path_hist));
		bi     = IDX_W'(a);
		g      = gshare_tab[gi];
		b      = bimodal_tab[bi];
		ch     = chooser_tab[bi];
		g_pred = g[1];
		b_pred = b[1];
		g_ok   = (g_pred == t);
		b_ok   = (b_pred == t);
		use_b  = ch[1];
		pred   = use_b ? b_pred : g_pred;

		// chooser: snap to the chosen side when it alone was right,
		// step toward the other side when only that one was right
		if (!use_b) begin
			if (g_ok && !b_ok)
				ch = CHOOSE_GSHARE_S;
			else if (!g_ok && b_ok)
				ch = ch + 1'b1;
		end else begin
			if (b_ok && !g_ok)
				ch = CHOOSE_BIMOD_S;
			else if (!b_ok && g_ok)
				ch = ch - 1'b1;
		end
		chooser_tab[bi] = ch;
		gshare_tab[gi]  = nudge_counter(g, t);
		bimodal_tab[bi] = nudge_counter(b, t);
		path_hist       = {path_hist[TBP_HISTORY_BITS-2:0], t};

		if (pred == t && hits_so_far != '1)
			hits_so_far = hits_so_far + 1'b1;
		if (branches_so_far != '1)
			branches_so_far = branches_so_far + 1'b1;

		v.predicted_taken    = pred;
		v.prediction_correct = (pred == t);
		v.used_bimodal       = use_b;
		v.correct_total      = hits_so_far;
		v.branch_total       = branches_so_far;
		return v;
	endfunction

	// Mostly short gaps, now and then a long one; 'quiet' gives none at all
	function automatic int pick_gap(logic quiet);
		int r;

		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void flag_field(string name, logic [TBP_CNT_W-1:0] want,
			logic [TBP_CNT_W-1:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Offer one branch transaction and hold it until the block takes it
	task automatic offer_branch(logic [TBP_ADDR_W-1:0] a, logic t);
		branch_ch.valid          <= 1'b1;
		branch_ch.branch_address <= a;
		branch_ch.was_taken      <= t;
		do
			@(posedge clk);
		while (!branch_ch.ready);
		branches_sent++;
	endtask

	task automatic idle_sender(int gap);
		if (gap > 0) begin
			branch_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// ---------------------------------------------------------------------
	// Result side: random back-pressure, one long hold-off once the pipe
	// has been busy for a while, and the comparison against the oldest verdict
	// ---------------------------------------------------------------------
	initial begin
		int              hold;
		int              tick;
		logic            quiet;
		logic            long_done;
		branch_verdict_t want;

		hold      = 0;
		tick      = 0;
		quiet     = 1'b0;
		long_done = 1'b0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (pending_verdicts.size() == 0) begin
					$display("%0t ns: result transaction with nothing expected, got %0h",
						$time, {result_ch.predicted_taken, result_ch.prediction_correct,
						result_ch.used_bimodal, result_ch.correct_total,
						result_ch.branch_total});
					mismatches++;
				end else begin
					want = pending_verdicts.pop_front();
					flag_field("predicted_taken", want.predicted_taken,
						result_ch.predicted_taken);
					flag_field("prediction_correct", want.prediction_correct,
						result_ch.prediction_correct);
					flag_field("used_bimodal", want.used_bimodal, result_ch.used_bimodal);
					flag_field("correct_total", want.correct_total, result_ch.correct_total);
					flag_field("branch_total", want.branch_total, result_ch.branch_total);
				end
				bimodal_picks += result_ch.used_bimodal;
				right_calls   += result_ch.prediction_correct;
			end

			// quiet is redrawn from tick: one time in four a stall-free stretch, else a bursty one
			tick++;
			if (tick % 64 == 0)
				quiet = ($urandom_range(0, 3) == 0);

			if (hold > 0) begin
				hold--;
			end else if (!long_done && results_seen >= 500) begin
				// long hold-off: the sender keeps going, so the block fills and
				// drops branch.ready
				hold      = LONG_HOLD;
				long_done = 1'b1;
			end else begin
				hold = pick_gap(quiet);
			end
			result_ch.ready <= (hold == 0);
		end
	end

	// Watchdog
	initial begin
		int cyc;

		cyc = 0;
		while (cyc < LIMIT_CYCLES) begin
			@(posedge clk);
			cyc++;
		end
		$display("%0t ns: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
		$display("FAILURE");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Branch side and run control
	// ---------------------------------------------------------------------
	initial begin
		logic [TBP_ADDR_W-1:0] a;
		logic [TBP_ADDR_W-1:0] last_a;
		logic                  t;
		logic                  quiet;
		int                    r;
		int                    k;
		branch_verdict_t       v;

		// shadow state after reset
		foreach (gshare_tab[i]) begin
			gshare_tab[i]  = CTR_RESET;
			bimodal_tab[i] = CTR_RESET;
			chooser_tab[i] = CHOOSE_GSHARE_S;
		end
		path_hist       = '0;
		hits_so_far     = '0;
		branches_so_far = '0;

		arst_n                   <= 1'b0;
		branch_ch.valid          <= 1'b0;
		branch_ch.branch_address <= '0;
		branch_ch.was_taken      <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows; ready stays low through the clearing pass, the first
		// offer simply waits it out
		for (int i = 0; i < N_PROBE; i++) begin
			idle_sender(pick_gap(i < 8));
			offer_branch(probe_rows[i].addr, probe_rows[i].taken);
			v = train_on_branch(probe_rows[i].addr, probe_rows[i].taken);
			pending_verdicts.insert(pending_verdicts.size(),
				probe_rows[i].typed ? probe_rows[i].want : v);
		end

		// hot branches: pairs k and k+8 alias on the table index and differ
		// only above it
		for (int i = 0; i < N_HOT / 2; i++) begin
			hot_addr[i]           = $urandom();
			hot_addr[i + N_HOT/2] = ($urandom() & ~IDX_MASK) | (hot_addr[i] & IDX_MASK);
		end
		for (int i = 0; i < N_HOT; i++) begin
			hot_pos[i] = 0;
			case ($urandom_range(0, 3))
				0: begin
					hot_pat[i] = 8'hFF;
					hot_len[i] = 1;
				end
				1: begin
					hot_pat[i] = 8'h00;
					hot_len[i] = 1;
				end
				2: begin
					// loop: taken len-1 times, then falls out
					hot_len[i] = $urandom_range(2, 8);
					hot_pat[i] = 8'((1 << (hot_len[i] - 1)) - 1);
				end
				default: begin
					hot_len[i] = $urandom_range(2, 8);
					hot_pat[i] = 8'($urandom());
				end
			endcase
		end

		// random part: mostly the hot branches with their patterns, some
		// back-to-back repeats on one index, the rest fully random noise
		quiet  = 1'b0;
		last_a = '0;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 64 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 72) begin
				k = $urandom_range(0, N_HOT - 1);
				a = hot_addr[k];
				t = hot_pat[k][hot_pos[k]];
				hot_pos[k] = (hot_pos[k] + 1) % hot_len[k];
			end else if (r < 85) begin
				a = last_a;
				t = $urandom_range(0, 1);
			end else begin
				a = $urandom();
				t = $urandom_range(0, 1);
			end
			last_a = a;
			idle_sender(pick_gap(quiet));
			offer_branch(a, t);
			pending_verdicts.insert(pending_verdicts.size(), train_on_branch(a, t));
		end
		branch_ch.valid <= 1'b0;

		// drain, then a few more cycles to catch anything extra
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d branch transactions (%0d directed), %0d results checked.",
			branches_sent, N_PROBE, results_seen);
		$display("Bimodal side chosen %0d times, %0d predictions right, %0d mismatches.",
			bimodal_picks, right_calls, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* tournament_branch_predictor.f */
hdl/tbp_pkg.sv
hdl/tbp_branch_if.sv
hdl/tbp_result_if.sv
hdl/tournament_branch_predictor.sv
bench/tournament_branch_predictor_tb.sv
